[rtl/map_point_frustum_test_assert.svh]
// Assertion macros for the map point frustum test block.
// Used by map_point_frustum_test.sv; compiled out when SYNTH is defined.
`ifndef MAP_POINT_FRUSTUM_TEST_ASSERT_SVH
`define MAP_POINT_FRUSTUM_TEST_ASSERT_SVH

`ifndef SYNTH
`define MPFT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("map_point_frustum_test: same-cycle check failed");
`define MPFT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("map_point_frustum_test: next-cycle check failed");
`else
`define MPFT_ASSERT_IMP(label, clk, rst, ante, cons)
`define MPFT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/mpft_pkg.sv]
// Shared widths, register indexes, reject codes and reset values
// for the map point frustum test block. No dependencies.
package mpft_pkg;

   localparam int COORD_W    = 32;
   localparam int NORMAL_W   = 16;
   localparam int UV_W       = 20;
   localparam int COS_W      = 16;
   localparam int REASON_W   = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   localparam int ROT_W    = 18;
   localparam int ROW_W    = 54;
   localparam int TRANS_W  = 32;
   localparam int FOCAL_W  = 24;
   localparam int PAIR_W   = 48;
   localparam int ISIZE_W  = 12;
   localparam int IMG_W    = 24;

   localparam int COS_ONE  = 16384;
   localparam int COS_HALF = 8192;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT0,
      CSR_ROT1,
      CSR_ROT2,
      CSR_TRANS_XY,
      CSR_TRANS_Z,
      CSR_FOCAL,
      CSR_PPOINT,
      CSR_ISIZE
   } csr_index_type;

   typedef enum logic [REASON_W-1:0] {
      R_NONE,
      R_BEHIND,
      R_U_OUT,
      R_V_OUT,
      R_ANGLE
   } reason_type;

   localparam logic [ROW_W-1:0]   ROT0_RESET   = 54'd65536;
   localparam logic [ROW_W-1:0]   ROT1_RESET   = 54'd17179869184;
   localparam logic [ROW_W-1:0]   ROT2_RESET   = 54'd4503599627370496;
   localparam logic [PAIR_W-1:0]  FOCAL_RESET  = 48'd2147483776000;
   localparam logic [PAIR_W-1:0]  PPOINT_RESET = 48'd1030792232960;
   localparam logic [IMG_W-1:0]   ISIZE_RESET  = 24'd1966720;

endpackage

[rtl/mpft_if.sv]
// Channel interfaces of the map point frustum test block: point request,
// result response and register write. Depends on mpft_pkg.
interface mpft_req_if import mpft_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;
   logic signed [COORD_W-1:0]  point_z;
   logic signed [NORMAL_W-1:0] normal_x;
   logic signed [NORMAL_W-1:0] normal_y;
   logic signed [NORMAL_W-1:0] normal_z;

   modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                 output ready);
endinterface

interface mpft_rsp_if import mpft_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    visible;
   logic [UV_W-1:0]         proj_u;
   logic [UV_W-1:0]         proj_v;
   logic signed [COS_W-1:0] view_cosine;
   logic [REASON_W-1:0]     reject_reason;

   modport source (output valid, visible, proj_u, proj_v, view_cosine, reject_reason,
                   input ready);
   modport sink (input valid, visible, proj_u, proj_v, view_cosine, reject_reason,
                 output ready);
endinterface

interface mpft_csr_if import mpft_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/map_point_frustum_test.sv]
// Map point frustum test: camera transform, pinhole projection, bounds and
// viewing angle culling. Depends on mpft_pkg, mpft_if and the assertion header.
//
// One item enters per cycle. The depth is set by the 31-step pipelined square
// root of the ray length and the 15-step pipelined cosine divide that follows
// it; the u and v divides (25 steps each) run alongside the root. The whole
// pipeline holds while a result waits at the output, so nothing is lost.
// Register writes are taken at once, every cycle.
`include "map_point_frustum_test_assert.svh"

module map_point_frustum_test import mpft_pkg::*; (
   input logic        clock,
   input logic        reset,
   mpft_req_if.sink   req_bus,
   mpft_rsp_if.source rsp_bus,
   mpft_csr_if.sink   csr_bus
);

   localparam int MR_W      = 50;
   localparam int ACC_W     = 52;
   localparam int PC_W      = 37;
   localparam int PO_W      = 52;
   localparam int MAG_W     = 51;
   localparam int BL_W      = 6;
   localparam int NU_W      = 62;
   localparam int NM_W      = 61;
   localparam int DD_W      = 36;
   localparam int DV_W      = 62;
   localparam int PON_W     = 31;
   localparam int NORM_BITS = 30;
   localparam int SQ_W      = 62;
   localparam int DP_W      = 47;
   localparam int DOT_W     = 48;
   localparam int SR_W      = 62;
   localparam int RT_W      = 31;
   localparam int Q_UV_W    = 25;
   localparam int UQ_W      = 28;
   localparam int DM_W      = 48;
   localparam int Q_C_W     = 15;
   localparam int CV_W      = 17;
   localparam int SQ_STEPS  = 31;
   localparam int LP_N      = SQ_STEPS + Q_C_W + 2;

   typedef struct packed {
      logic              pcz_pos;
      logic [DD_W-1:0]   dd;
      logic              sign_u;
      logic              over_u;
      logic [NM_W-1:0]   nm_u;
      logic              sign_v;
      logic              over_v;
      logic [NM_W-1:0]   nm_v;
   } uv_type;

   typedef struct packed {
      logic                    pcz_pos;
      logic                    mag_zero;
      logic [DD_W-1:0]         dd;
      logic                    sign_u;
      logic                    over_u;
      logic                    sign_v;
      logic                    over_v;
      logic [NM_W-1:0]         rem_u;
      logic [NM_W-1:0]         rem_v;
      logic [Q_UV_W-1:0]       q_u;
      logic [Q_UV_W-1:0]       q_v;
      logic [SR_W-1:0]         sq_rem;
      logic [RT_W-1:0]         root;
      logic signed [DOT_W-1:0] dot;
      logic                    u_bad;
      logic                    v_bad;
      logic [UV_W-1:0]         u_val;
      logic [UV_W-1:0]         v_val;
      logic                    dsign;
      logic                    over_c;
      logic [DM_W-1:0]         rem_c;
      logic [Q_C_W-1:0]        q_c;
   } lp_type;

   typedef struct packed {
      logic                    visible;
      logic [UV_W-1:0]         proj_u;
      logic [UV_W-1:0]         proj_v;
      logic signed [COS_W-1:0] view_cosine;
      logic [REASON_W-1:0]     reject_reason;
   } rsp_type;

   // ---------------------------------------------------------------- registers
   logic [ROW_W-1:0]   rot_ff [3];
   logic [TRANS_W*2-1:0] trans_xy_ff;
   logic [TRANS_W-1:0] trans_z_ff;
   logic [PAIR_W-1:0]  focal_ff;
   logic [PAIR_W-1:0]  ppoint_ff;
   logic [IMG_W-1:0]   isize_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= ROT0_RESET;
         rot_ff[1]   <= ROT1_RESET;
         rot_ff[2]   <= ROT2_RESET;
         trans_xy_ff <= '0;
         trans_z_ff  <= '0;
         focal_ff    <= FOCAL_RESET;
         ppoint_ff   <= PPOINT_RESET;
         isize_ff    <= ISIZE_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ROT0:     rot_ff[0]   <= csr_bus.data[ROW_W-1:0];
            CSR_ROT1:     rot_ff[1]   <= csr_bus.data[ROW_W-1:0];
            CSR_ROT2:     rot_ff[2]   <= csr_bus.data[ROW_W-1:0];
            CSR_TRANS_XY: trans_xy_ff <= csr_bus.data[TRANS_W*2-1:0];
            CSR_TRANS_Z:  trans_z_ff  <= csr_bus.data[TRANS_W-1:0];
            CSR_FOCAL:    focal_ff    <= csr_bus.data[PAIR_W-1:0];
            CSR_PPOINT:   ppoint_ff   <= csr_bus.data[PAIR_W-1:0];
            CSR_ISIZE:    isize_ff    <= csr_bus.data[IMG_W-1:0];
            default: ;
         endcase
      end
   end

   logic signed [ROT_W-1:0]   rot [3][3];
   logic signed [TRANS_W-1:0] tr [3];
   logic [FOCAL_W-1:0]        fx, fy, cx, cy;
   logic [UV_W-1:0]           wq8, hq8;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rot[i][j] = rot_ff[i][ROT_W*j +: ROT_W];
         end
      end
      tr[0] = trans_xy_ff[TRANS_W-1:0];
      tr[1] = trans_xy_ff[TRANS_W*2-1:TRANS_W];
      tr[2] = trans_z_ff;
   end

   assign fx  = focal_ff[FOCAL_W-1:0];
   assign fy  = focal_ff[PAIR_W-1:FOCAL_W];
   assign cx  = ppoint_ff[FOCAL_W-1:0];
   assign cy  = ppoint_ff[PAIR_W-1:FOCAL_W];
   assign wq8 = {isize_ff[ISIZE_W-1:0], 8'b0};
   assign hq8 = {isize_ff[IMG_W-1:ISIZE_W], 8'b0};

   // whole pipeline moves unless a result is held at the output
   logic    adv;
   logic    out_vld_ff;
   rsp_type out_ff;

   assign adv           = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------------------------------------------------------- stage 1
   logic signed [COORD_W-1:0]  pin [3];
   logic signed [NORMAL_W-1:0] nin [3];
   logic signed [MR_W-1:0]     s1_mr_in [3][3];
   logic signed [MR_W-1:0]     s1_mt_in [3][3];
   logic                       s1_vld_ff;
   logic signed [COORD_W-1:0]  s1_p_ff [3];
   logic signed [NORMAL_W-1:0] s1_n_ff [3];
   logic signed [MR_W-1:0]     s1_mr_ff [3][3];
   logic signed [MR_W-1:0]     s1_mt_ff [3][3];

   assign pin[0] = req_bus.point_x;
   assign pin[1] = req_bus.point_y;
   assign pin[2] = req_bus.point_z;
   assign nin[0] = req_bus.normal_x;
   assign nin[1] = req_bus.normal_y;
   assign nin[2] = req_bus.normal_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s1_mr_in[i][j] = MR_W'(rot[i][j]) * MR_W'(pin[j]);
            // R^T t terms of the ray from the camera centre
            s1_mt_in[i][j] = MR_W'(rot[i][j]) * MR_W'(tr[i]);
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [PC_W-1:0]     s2_pc_in [3];
   logic signed [PO_W-1:0]     s2_po_in [3];
   logic signed [PC_W-1:0]     s2_pc_ff [3];
   logic signed [PO_W-1:0]     s2_po_ff [3];
   logic signed [NORMAL_W-1:0] s2_n_ff [3];
   logic                       s2_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pc_in[i] = PC_W'((ACC_W'(s1_mr_ff[i][0]) + ACC_W'(s1_mr_ff[i][1])
                              + ACC_W'(s1_mr_ff[i][2])) >>> 16) + PC_W'(tr[i]);
         s2_po_in[i] = (PO_W'(s1_p_ff[i]) <<< 16) + PO_W'(s1_mt_ff[0][i])
                       + PO_W'(s1_mt_ff[1][i]) + PO_W'(s1_mt_ff[2][i]);
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [NU_W-1:0]     s3_nu_in, s3_nv_in;
   logic [MAG_W-1:0]           s3_apo_in [3];
   logic signed [NU_W-1:0]     s3_nu_ff, s3_nv_ff;
   logic [MAG_W-1:0]           s3_apo_ff [3];
   logic signed [PO_W-1:0]     s3_po_ff [3];
   logic signed [PC_W-1:0]     s3_pcz_ff;
   logic signed [NORMAL_W-1:0] s3_n_ff [3];
   logic                       s3_vld_ff;

   assign s3_nu_in = NU_W'(signed'({1'b0, fx})) * NU_W'(s2_pc_ff[0]);
   assign s3_nv_in = NU_W'(signed'({1'b0, fy})) * NU_W'(s2_pc_ff[1]);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s3_apo_in[j] = s2_po_ff[j][PO_W-1] ? MAG_W'(-s2_po_ff[j]) : MAG_W'(s2_po_ff[j]);
      end
   end

   // ---------------------------------------------------------------- stage 4
   uv_type                     s4_uv_in;
   logic [MAG_W-1:0]           s4_mag_in;
   uv_type                     s4_uv_ff;
   logic [MAG_W-1:0]           s4_mag_ff;
   logic signed [PO_W-1:0]     s4_po_ff [3];
   logic signed [NORMAL_W-1:0] s4_n_ff [3];
   logic                       s4_vld_ff;

   always_comb begin
      s4_uv_in.pcz_pos = !s3_pcz_ff[PC_W-1] && (s3_pcz_ff != '0);
      s4_uv_in.dd      = DD_W'(s3_pcz_ff);
      s4_uv_in.sign_u  = s3_nu_ff[NU_W-1];
      s4_uv_in.nm_u    = s3_nu_ff[NU_W-1] ? NM_W'(-s3_nu_ff) : NM_W'(s3_nu_ff);
      s4_uv_in.sign_v  = s3_nv_ff[NU_W-1];
      s4_uv_in.nm_v    = s3_nv_ff[NU_W-1] ? NM_W'(-s3_nv_ff) : NM_W'(s3_nv_ff);
      // quotient of 2^25 or more can never land inside the image
      s4_uv_in.over_u  = {1'b0, s4_uv_in.nm_u} >= (DV_W'(s4_uv_in.dd) << Q_UV_W);
      s4_uv_in.over_v  = {1'b0, s4_uv_in.nm_v} >= (DV_W'(s4_uv_in.dd) << Q_UV_W);
      s4_mag_in = s3_apo_ff[0];
      if (s3_apo_ff[1] > s4_mag_in) s4_mag_in = s3_apo_ff[1];
      if (s3_apo_ff[2] > s4_mag_in) s4_mag_in = s3_apo_ff[2];
   end

   // ---------------------------------------------------------------- stage 5
   logic [BL_W-1:0]            s5_bl_in;
   logic [BL_W-1:0]            s5_bl_ff;
   uv_type                     s5_uv_ff;
   logic signed [PO_W-1:0]     s5_po_ff [3];
   logic signed [NORMAL_W-1:0] s5_n_ff [3];
   logic                       s5_vld_ff;

   always_comb begin
      s5_bl_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (s4_mag_ff[i]) s5_bl_in = BL_W'(i + 1);
      end
   end

   // ---------------------------------------------------------------- stage 6
   logic signed [PON_W-1:0]    s6_pon_in [3];
   logic signed [PON_W-1:0]    s6_pon_ff [3];
   logic                       s6_mz_ff;
   uv_type                     s6_uv_ff;
   logic signed [NORMAL_W-1:0] s6_n_ff [3];
   logic                       s6_vld_ff;

   // scale the ray so its largest component has NORM_BITS significant bits
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (s5_bl_ff > BL_W'(NORM_BITS)) begin
            s6_pon_in[j] = PON_W'(s5_po_ff[j] >>> (s5_bl_ff - BL_W'(NORM_BITS)));
         end else begin
            s6_pon_in[j] = PON_W'(s5_po_ff[j] <<< (BL_W'(NORM_BITS) - s5_bl_ff));
         end
      end
   end

   // ---------------------------------------------------------------- stage 7
   logic signed [SQ_W-1:0] s7_sq_in [3];
   logic signed [DP_W-1:0] s7_dp_in [3];
   logic signed [SQ_W-1:0] s7_sq_ff [3];
   logic signed [DP_W-1:0] s7_dp_ff [3];
   logic                   s7_mz_ff;
   uv_type                 s7_uv_ff;
   logic                   s7_vld_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s7_sq_in[j] = SQ_W'(s6_pon_ff[j]) * SQ_W'(s6_pon_ff[j]);
         s7_dp_in[j] = DP_W'(s6_pon_ff[j]) * DP_W'(s6_n_ff[j]);
      end
   end

   // ---------------------------------------------------------------- front regs
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_bus.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff   <= pin;
         s1_n_ff   <= nin;
         s1_mr_ff  <= s1_mr_in;
         s1_mt_ff  <= s1_mt_in;
         s2_pc_ff  <= s2_pc_in;
         s2_po_ff  <= s2_po_in;
         s2_n_ff   <= s1_n_ff;
         s3_nu_ff  <= s3_nu_in;
         s3_nv_ff  <= s3_nv_in;
         s3_apo_ff <= s3_apo_in;
         s3_po_ff  <= s2_po_ff;
         s3_pcz_ff <= s2_pc_ff[2];
         s3_n_ff   <= s2_n_ff;
         s4_uv_ff  <= s4_uv_in;
         s4_mag_ff <= s4_mag_in;
         s4_po_ff  <= s3_po_ff;
         s4_n_ff   <= s3_n_ff;
         s5_bl_ff  <= s5_bl_in;
         s5_uv_ff  <= s4_uv_ff;
         s5_po_ff  <= s4_po_ff;
         s5_n_ff   <= s4_n_ff;
         s6_pon_ff <= s6_pon_in;
         s6_mz_ff  <= (s5_bl_ff == '0);
         s6_uv_ff  <= s5_uv_ff;
         s6_n_ff   <= s5_n_ff;
         s7_sq_ff  <= s7_sq_in;
         s7_dp_ff  <= s7_dp_in;
         s7_mz_ff  <= s6_mz_ff;
         s7_uv_ff  <= s6_uv_ff;
      end
   end

   // ---------------------------------------------------------------- long pipe
   lp_type          lp_ff [LP_N];
   logic [LP_N-1:0] lp_vld_ff;
   lp_type          lp0_in;

   always_comb begin
      lp0_in         = '0;
      lp0_in.pcz_pos = s7_uv_ff.pcz_pos;
      lp0_in.mag_zero = s7_mz_ff;
      lp0_in.dd      = s7_uv_ff.dd;
      lp0_in.sign_u  = s7_uv_ff.sign_u;
      lp0_in.over_u  = s7_uv_ff.over_u;
      lp0_in.sign_v  = s7_uv_ff.sign_v;
      lp0_in.over_v  = s7_uv_ff.over_v;
      lp0_in.rem_u   = s7_uv_ff.nm_u;
      lp0_in.rem_v   = s7_uv_ff.nm_v;
      lp0_in.sq_rem  = SR_W'(s7_sq_ff[0]) + SR_W'(s7_sq_ff[1]) + SR_W'(s7_sq_ff[2]);
      lp0_in.dot     = DOT_W'(s7_dp_ff[0]) + DOT_W'(s7_dp_ff[1]) + DOT_W'(s7_dp_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_vld_ff <= '0;
      end else if (adv) begin
         lp_vld_ff <= {lp_vld_ff[LP_N-2:0], s7_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lp_ff[0] <= lp0_in;
      end
   end

   for (genvar k = 1; k < LP_N; k++) begin : g_lp
      lp_type lp_in;

      if (k <= SQ_STEPS) begin : g_sq
         // one root bit per stage, and in the first Q_UV_W stages one quotient bit of u and v alongside
         localparam int B = SQ_STEPS - k;
         logic [63:0]       trial;
         logic [NM_W-1:0]   ru, rv;
         logic [Q_UV_W-1:0] qu, qv;

         assign trial = (64'(lp_ff[k-1].root) << (B + 1)) | (64'(1) << (2 * B));

         if (k <= Q_UV_W) begin : g_div
            localparam int BD = Q_UV_W - k;
            logic [DV_W-1:0] dsh;

            assign dsh = DV_W'(lp_ff[k-1].dd) << BD;

            always_comb begin
               ru = lp_ff[k-1].rem_u;
               qu = lp_ff[k-1].q_u;
               rv = lp_ff[k-1].rem_v;
               qv = lp_ff[k-1].q_v;
               if ({1'b0, lp_ff[k-1].rem_u} >= dsh) begin
                  ru     = lp_ff[k-1].rem_u - NM_W'(dsh);
                  qu[BD] = 1'b1;
               end
               if ({1'b0, lp_ff[k-1].rem_v} >= dsh) begin
                  rv     = lp_ff[k-1].rem_v - NM_W'(dsh);
                  qv[BD] = 1'b1;
               end
            end
         end else begin : g_hold
            assign ru = lp_ff[k-1].rem_u;
            assign rv = lp_ff[k-1].rem_v;
            assign qu = lp_ff[k-1].q_u;
            assign qv = lp_ff[k-1].q_v;
         end

         always_comb begin
            lp_in       = lp_ff[k-1];
            lp_in.rem_u = ru;
            lp_in.rem_v = rv;
            lp_in.q_u   = qu;
            lp_in.q_v   = qv;
            if ({2'b0, lp_ff[k-1].sq_rem} >= trial) begin
               lp_in.sq_rem = lp_ff[k-1].sq_rem - SR_W'(trial);
               lp_in.root   = lp_ff[k-1].root | (RT_W'(1) << B);
            end
         end
      end else if (k == SQ_STEPS + 1) begin : g_prep
         // floor the signed quotients, add the principal point, test bounds, set up the cosine divide
         logic                    unz, vnz;
         logic signed [UQ_W-1:0]  uq, vq, uf, vf;
         logic [DM_W-1:0]         dmag;

         assign unz  = lp_ff[k-1].rem_u != '0;
         assign vnz  = lp_ff[k-1].rem_v != '0;
         assign uq   = lp_ff[k-1].sign_u ? -UQ_W'(lp_ff[k-1].q_u) - UQ_W'(unz)
                                         : UQ_W'(lp_ff[k-1].q_u);
         assign vq   = lp_ff[k-1].sign_v ? -UQ_W'(lp_ff[k-1].q_v) - UQ_W'(vnz)
                                         : UQ_W'(lp_ff[k-1].q_v);
         assign uf   = uq + signed'(UQ_W'(cx));
         assign vf   = vq + signed'(UQ_W'(cy));
         assign dmag = lp_ff[k-1].dot[DOT_W-1] ? DM_W'(-lp_ff[k-1].dot)
                                               : DM_W'(lp_ff[k-1].dot);

         always_comb begin
            lp_in        = lp_ff[k-1];
            lp_in.u_bad  = lp_ff[k-1].over_u || uf[UQ_W-1]
                           || (uf > signed'(UQ_W'(wq8)));
            lp_in.v_bad  = lp_ff[k-1].over_v || vf[UQ_W-1]
                           || (vf > signed'(UQ_W'(hq8)));
            lp_in.u_val  = uf[UV_W-1:0];
            lp_in.v_val  = vf[UV_W-1:0];
            lp_in.dsign  = lp_ff[k-1].dot[DOT_W-1];
            lp_in.over_c = dmag >= (DM_W'(lp_ff[k-1].root) << Q_C_W);
            lp_in.rem_c  = dmag;
            lp_in.q_c    = '0;
         end
      end else begin : g_cos
         localparam int BC = LP_N - 1 - k;
         logic [DM_W-1:0] lsh;

         assign lsh = DM_W'(lp_ff[k-1].root) << BC;

         always_comb begin
            lp_in = lp_ff[k-1];
            if (lp_ff[k-1].rem_c >= lsh) begin
               lp_in.rem_c = lp_ff[k-1].rem_c - lsh;
               lp_in.q_c[BC] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lp_ff[k] <= lp_in;
         end
      end
   end

   // ---------------------------------------------------------------- output
   lp_type                 fin;
   logic signed [CV_W-1:0] cmag, cv_raw, cv;
   logic                   cnz;
   reason_type             reason;
   rsp_type                out_in;

   assign fin    = lp_ff[LP_N-1];
   assign cnz    = fin.rem_c != '0;
   assign cmag   = signed'(CV_W'(fin.q_c));
   assign cv_raw = fin.dsign ? -cmag - CV_W'(cnz) : cmag;

   always_comb begin
      if (fin.over_c) begin
         cv = fin.dsign ? CV_W'(-COS_ONE) : CV_W'(COS_ONE);
      end else if (cv_raw > CV_W'(COS_ONE)) begin
         cv = CV_W'(COS_ONE);
      end else if (cv_raw < CV_W'(-COS_ONE)) begin
         cv = CV_W'(-COS_ONE);
      end else begin
         cv = cv_raw;
      end

      if (!fin.pcz_pos) begin
         reason = R_BEHIND;
      end else if (fin.u_bad) begin
         reason = R_U_OUT;
      end else if (fin.v_bad) begin
         reason = R_V_OUT;
      end else if (fin.mag_zero || (fin.root == '0) || (cv < CV_W'(COS_HALF))) begin
         reason = R_ANGLE;
      end else begin
         reason = R_NONE;
      end

      out_in               = '0;
      out_in.reject_reason = reason;
      if (reason == R_NONE) begin
         out_in.visible     = 1'b1;
         out_in.proj_u      = fin.u_val;
         out_in.proj_v      = fin.v_val;
         out_in.view_cosine = COS_W'(cv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= lp_vld_ff[LP_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.visible       = out_ff.visible;
   assign rsp_bus.proj_u        = out_ff.proj_u;
   assign rsp_bus.proj_v        = out_ff.proj_v;
   assign rsp_bus.view_cosine   = out_ff.view_cosine;
   assign rsp_bus.reject_reason = out_ff.reject_reason;

   // ---------------------------------------------------------------- checks
   logic chk_vis_match, chk_rsp_zero, chk_cos_range;

   assign chk_vis_match = rsp_bus.visible == (rsp_bus.reject_reason == R_NONE);
   assign chk_rsp_zero  = (rsp_bus.proj_u == '0) && (rsp_bus.proj_v == '0)
                          && (rsp_bus.view_cosine == '0);
   assign chk_cos_range = (rsp_bus.view_cosine >= COS_W'(COS_HALF))
                          && (rsp_bus.view_cosine <= COS_W'(COS_ONE));

   `MPFT_ASSERT_IMP(a_vis_reason, clock, reset, rsp_bus.valid, chk_vis_match)
   `MPFT_ASSERT_IMP(a_reject_zero, clock, reset, rsp_bus.valid && !rsp_bus.visible, chk_rsp_zero)
   `MPFT_ASSERT_IMP(a_vis_cos, clock, reset, rsp_bus.valid && rsp_bus.visible, chk_cos_range)
   `MPFT_ASSERT_NXT(a_stall_hold, clock, reset, !adv, $stable(lp_vld_ff) && $stable(s7_vld_ff))

endmodule
